// ===== sv/adsf_pkg.sv =====
//------------------------------------------------------------------------------
// adsf_pkg
// shared types and constants of the adc sample despike filter
//------------------------------------------------------------------------------
`default_nettype none

package adsf_pkg;

   localparam int SampleWidth  = 24;
   localparam int OutqDepth    = 8;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [SampleWidth-1:0]        limit_type;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] RegNearLimit = 2'd0;
   localparam logic [1:0] RegJumpLimit = 2'd1;
   localparam logic [1:0] RegLowLimit  = 2'd2;
   localparam logic [1:0] RegHighLimit = 2'd3;

   localparam limit_type  NearLimitReset = 24'd200000;
   localparam limit_type  JumpLimitReset = 24'd500000;
   localparam sample_type LowLimitReset  = 24'sd3400000;
   localparam sample_type HighLimitReset = 24'sd4300000;

   localparam sample_type SampleMax = 24'sh7FFFFF;
   localparam sample_type SampleMin = 24'sh800000;

   typedef struct packed {
      limit_type  near_limit;
      limit_type  jump_limit;
      sample_type low_limit;
      sample_type high_limit;
   } cfg_type;

   typedef struct packed {
      sample_type sample;
      logic       end_of_capture;
   } word_type;

   // up to two result words from one filter step, middle word first
   typedef struct packed {
      logic     mid_valid;
      word_type mid_word;
      logic     new_valid;
      word_type new_word;
   } push_type;

endpackage

`default_nettype wire

// ===== sv/adsf_if.sv =====
//------------------------------------------------------------------------------
// adsf_req_if / adsf_rsp_if
// valid/ready channels carrying input samples and filtered results
//------------------------------------------------------------------------------
`default_nettype none

interface adsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_high;
   logic [7:0] byte_mid;
   logic [7:0] byte_low;
   logic       last;

   modport source (output valid, output byte_high, output byte_mid, output byte_low,
                   output last, input ready);
   modport sink   (input valid, input byte_high, input byte_mid, input byte_low,
                   input last, output ready);
endinterface

interface adsf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample;
   logic               end_of_capture;

   modport source (output valid, output sample, output end_of_capture, input ready);
   modport sink   (input valid, input sample, input end_of_capture, output ready);
endinterface

`default_nettype wire

// ===== sv/adsf_csr.sv =====
//------------------------------------------------------------------------------
// adsf_csr
// apb register file holding the four filter limits
//------------------------------------------------------------------------------
`default_nettype none

module adsf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [adsf_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [adsf_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [adsf_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready,
   output adsf_pkg::cfg_type                    cfg
);
   import adsf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            RegNearLimit: cfg_in.near_limit = pwdata[SampleWidth-1:0];
            RegJumpLimit: cfg_in.jump_limit = pwdata[SampleWidth-1:0];
            RegLowLimit:  cfg_in.low_limit  = $signed(pwdata[SampleWidth-1:0]);
            RegHighLimit: cfg_in.high_limit = $signed(pwdata[SampleWidth-1:0]);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         RegNearLimit: prdata = CsrDataWidth'(cfg_ff.near_limit);
         RegJumpLimit: prdata = CsrDataWidth'(cfg_ff.jump_limit);
         RegLowLimit:  prdata = CsrDataWidth'(unsigned'(cfg_ff.low_limit));
         RegHighLimit: prdata = CsrDataWidth'(unsigned'(cfg_ff.high_limit));
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit <= NearLimitReset;
         cfg_ff.jump_limit <= JumpLimitReset;
         cfg_ff.low_limit  <= LowLimitReset;
         cfg_ff.high_limit <= HighLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/adsf_core.sv =====
//------------------------------------------------------------------------------
// adsf_core
// input register, despike/window logic and the two-sample history
//------------------------------------------------------------------------------
`default_nettype none

module adsf_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         byte_high,
   input  logic [7:0]         byte_mid,
   input  logic [7:0]         byte_low,
   input  logic               last,
   input  adsf_pkg::cfg_type  cfg,
   output logic               busy,
   output adsf_pkg::push_type push
);
   import adsf_pkg::*;

   logic                   stage_valid_ff;
   logic [SampleWidth-1:0] stage_raw_ff;
   logic                   stage_last_ff;

   sample_type older_ff, older_in;
   sample_type middle_ff, middle_in;
   logic [1:0] fill_ff, fill_in;

   sample_type         new_s;
   logic signed [24:0] d_new, d_mid, half_new, mean_sum, mean_half;
   logic [24:0]        mag_new, mag_mid;
   logic signed [25:0] rep_sum;
   sample_type         rep_sat, mid_fixed, new_fixed;
   logic               filt_en, near_hit, jump_hit, repair, out_window;

   assign new_s = $signed(stage_raw_ff);

   // distances from the older sample
   assign d_new   = {older_ff[23], older_ff} - {new_s[23], new_s};
   assign d_mid   = {older_ff[23], older_ff} - {middle_ff[23], middle_ff};
   assign mag_new = d_new[24] ? 25'(-d_new) : d_new;
   assign mag_mid = d_mid[24] ? 25'(-d_mid) : d_mid;

   assign near_hit = mag_new < {1'b0, cfg.near_limit};
   assign jump_hit = mag_mid > {1'b0, cfg.jump_limit};

   // older + d_new/2 rounded toward zero, then clamp to 24 bits
   assign half_new = $signed(d_new + 25'(d_new[24])) >>> 1;
   assign rep_sum  = {{2{older_ff[23]}}, older_ff} + {half_new[24], half_new};

   always_comb begin
      if (rep_sum[25:23] == 3'b000 || rep_sum[25:23] == 3'b111) begin
         rep_sat = rep_sum[23:0];
      end else if (rep_sum[25]) begin
         rep_sat = SampleMin;
      end else begin
         rep_sat = SampleMax;
      end
   end

   assign filt_en = (fill_ff == 2'd2) && (older_ff != '0);
   assign repair  = filt_en &&
                    ((near_hit && jump_hit) || ($signed(middle_ff) > $signed(cfg.high_limit)));
   assign mid_fixed = repair ? rep_sat : middle_ff;

   // mean of repaired middle and older, rounded toward zero
   assign mean_sum  = {mid_fixed[23], mid_fixed} + {older_ff[23], older_ff};
   assign mean_half = $signed(mean_sum + 25'(mean_sum[24])) >>> 1;

   assign out_window = ($signed(new_s) < $signed(cfg.low_limit)) ||
                       ($signed(new_s) > $signed(cfg.high_limit));
   assign new_fixed  = (filt_en && out_window) ? mean_half[23:0] : new_s;

   always_comb begin
      push.mid_valid               = stage_valid_ff && (fill_ff != 2'd0);
      push.mid_word.sample         = mid_fixed;
      push.mid_word.end_of_capture = 1'b0;
      push.new_valid               = stage_valid_ff && stage_last_ff;
      push.new_word.sample         = new_fixed;
      push.new_word.end_of_capture = 1'b1;
   end

   always_comb begin
      older_in  = older_ff;
      middle_in = middle_ff;
      fill_in   = fill_ff;
      if (stage_valid_ff) begin
         if (stage_last_ff) begin
            older_in  = '0;
            middle_in = '0;
            fill_in   = 2'd0;
         end else begin
            older_in  = mid_fixed;
            middle_in = new_fixed;
            fill_in   = (fill_ff == 2'd2) ? 2'd2 : fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         older_ff       <= '0;
         middle_ff      <= '0;
         fill_ff        <= 2'd0;
      end else begin
         stage_valid_ff <= in_valid;
         older_ff       <= older_in;
         middle_ff      <= middle_in;
         fill_ff        <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         stage_raw_ff  <= {byte_high, byte_mid, byte_low};
         stage_last_ff <= last;
      end
   end

   assign busy = stage_valid_ff;

endmodule

`default_nettype wire

// ===== sv/adsf_outq.sv =====
//------------------------------------------------------------------------------
// adsf_outq
// result queue taking up to two words a cycle and giving one
//------------------------------------------------------------------------------
`default_nettype none

module adsf_outq #(
   parameter int DEPTH = adsf_pkg::OutqDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  adsf_pkg::push_type push,
   input  logic               busy,
   output logic               room,
   output logic               out_valid,
   output adsf_pkg::word_type out_word,
   input  logic               out_ready
);
   import adsf_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   word_type                mem_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CntWidth-1:0]     count_ff, count_in;
   logic [1:0]              n_push;
   logic                    pop;

   function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign n_push  = 2'(push.mid_valid) + 2'(push.new_valid);
   assign wr_next = bump(wr_ptr_ff);
   assign pop     = (count_ff != '0) && out_ready;

   // room for two words from the stage register and two from the new word
   assign room = ({1'b0, count_ff} + (busy ? (CntWidth+1)'(2) : '0))
                 <= (CntWidth+1)'(DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      case (n_push)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = bump(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntWidth'(n_push) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.mid_valid) begin
         mem_ff[wr_ptr_ff] <= push.mid_word;
         if (push.new_valid) begin
            mem_ff[wr_next] <= push.new_word;
         end
      end else if (push.new_valid) begin
         mem_ff[wr_ptr_ff] <= push.new_word;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== sv/adc_sample_despike_filter.sv =====
//------------------------------------------------------------------------------
// adc_sample_despike_filter
// despike and window filter for signed 24-bit adc samples
//------------------------------------------------------------------------------
// A new sample word is accepted every cycle while the result queue has room.
// Each word is captured in an input register and filtered in the next cycle
// by one pass of compare/average logic; its results are written into an
// eight-word queue and show on the rsp channel from its registers. A filtered
// sample leaves one word late (it is final only once its successor is seen);
// a word with last set flushes the held sample and its own, giving up to two
// result words. Sustained rate is one word per cycle, bounded by the rsp side
// taking one result word per cycle; req ready drops when the queue cannot take
// the two words that the staged and the incoming sample may each produce.
`default_nettype none

module adc_sample_despike_filter #(
   parameter int OUTQ_DEPTH = adsf_pkg::OutqDepth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   adsf_req_if.sink                             req_chan,
   adsf_rsp_if.source                           rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [adsf_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [adsf_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [adsf_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready
);
   import adsf_pkg::*;

   cfg_type  cfg;
   push_type push;
   word_type out_word;
   logic     busy;
   logic     room;
   logic     in_valid;

   // limit registers
   adsf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // a word is taken whenever the queue can absorb the worst case
   assign req_chan.ready = room;
   assign in_valid       = req_chan.valid && room;

   // input register, filter pass and sample history
   adsf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .byte_high (req_chan.byte_high),
      .byte_mid  (req_chan.byte_mid),
      .byte_low  (req_chan.byte_low),
      .last      (req_chan.last),
      .cfg       (cfg),
      .busy      (busy),
      .push      (push)
   );

   // result queue decouples the rsp side from the filter
   adsf_outq #(
      .DEPTH (OUTQ_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .busy      (busy),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_word  (out_word),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.sample         = out_word.sample;
   assign rsp_chan.end_of_capture = out_word.end_of_capture;

endmodule

`default_nettype wire

// ===== sv/adsf_checker.sv =====
//------------------------------------------------------------------------------
// adsf_checker
// port-level checks of the despike filter, bound to the top level
//------------------------------------------------------------------------------
`default_nettype none

module adsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_sample
);

   logic req_take;

   assign req_take = req_valid && req_ready;

   // nothing queued right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   // a last word always yields a result once through the input register and queue
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last) |=> ##1 rsp_valid)
      else $error("no result for last word");

   // results only appear for a word taken through the input register and queue
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_take, 2))
      else $error("result without input word");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("stalled result changed");

endmodule

bind adc_sample_despike_filter adsf_checker u_adsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_last   (req_chan.last),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// self-checking bench for the adc sample despike filter
//------------------------------------------------------------------------------
// Sample words go in on the req channel and are mirrored by a predictor that
// keeps its own copy of the two held samples, the fill count and the four
// limit registers. Every accepted rsp word is checked against the oldest
// predicted word. Directed tests cover filling, flushing, the zero older
// sample, window replacement, spike repair and saturation. Random captures
// then run under several limit settings, with random gaps on both channels.
//------------------------------------------------------------------------------

module tb_top;
   import adsf_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 8;
   localparam int PhaseWords = 230;

   logic clock = 1'b0;
   logic reset;

   // apb-style register port
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   adsf_req_if req_if ();
   adsf_rsp_if rsp_if ();

   adc_sample_despike_filter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state: held samples, fill count and limit registers
   cfg_type    filter_cfg;
   sample_type held_older;
   sample_type held_middle;
   int         held_count;

   // predicted result words, oldest first
   word_type   filtered_queue[$];

   // run bookkeeping
   int  fail_count = 0;
   int  cycle_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  captures_run = 0;
   int  settings_used = 0;
   bit  sender_idle = 1'b0;
   bit  receiver_idle = 1'b0;
   int  rsp_wait = 0;

   always #5 clock = ~clock;

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, filtered_queue.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one filter step of the predictor for one accepted sample word
   task automatic despike_step(input logic [23:0] raw, input logic last);
      sample_type fresh;
      word_type   w;
      longint     s, o, m, d_new, d_mid, mag_new, mag_mid, rep;
      fresh = raw;
      s = fresh;
      o = held_older;
      m = held_middle;
      // filtering needs two held samples and a nonzero older one
      if (held_count >= 2 && held_older != 0) begin
         d_new = o - s;
         d_mid = o - m;
         mag_new = (d_new < 0) ? -d_new : d_new;
         mag_mid = (d_mid < 0) ? -d_mid : d_mid;
         // extrapolated middle, clamped to the 24-bit range
         rep = o + d_new / 2;
         if (rep > SampleMax) rep = SampleMax;
         if (rep < SampleMin) rep = SampleMin;
         // spike repair, or a middle above the high limit
         if ((mag_new < longint'(filter_cfg.near_limit) &&
              mag_mid > longint'(filter_cfg.jump_limit)) ||
             m > filter_cfg.high_limit)
            m = rep;
         // new sample outside the window takes the mean of the repaired pair
         if (s < filter_cfg.low_limit || s > filter_cfg.high_limit)
            s = (m + o) / 2;
      end
      // the held middle sample is final now and leaves first
      if (held_count >= 1) begin
         w.sample = m[23:0];
         w.end_of_capture = 1'b0;
         filtered_queue.push_back(w);
      end
      if (last) begin
         w.sample = s[23:0];
         w.end_of_capture = 1'b1;
         filtered_queue.push_back(w);
         held_older = '0;
         held_middle = '0;
         held_count = 0;
      end else begin
         held_older = m[23:0];
         held_middle = s[23:0];
         if (held_count < 2) held_count++;
      end
   endtask

   // drive one sample word and wait for it to be taken
   task automatic send_word(input logic [23:0] raw, input logic last);
      int gap;
      gap = sender_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.byte_high <= raw[23:16];
      req_if.byte_mid  <= raw[15:8];
      req_if.byte_low  <= raw[7:0];
      req_if.last      <= last;
      do @(posedge clock); while (!req_if.ready);
      despike_step(raw, last);
      words_sent++;
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [1:0] idx, input logic [23:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {8'h00, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         RegNearLimit: filter_cfg.near_limit = value;
         RegJumpLimit: filter_cfg.jump_limit = value;
         RegLowLimit:  filter_cfg.low_limit  = value;
         RegHighLimit: filter_cfg.high_limit = value;
         default: ;
      endcase
   endtask

   task automatic set_limits(input logic [23:0] near, input logic [23:0] jump,
                             input logic [23:0] lo, input logic [23:0] hi);
      csr_write(RegNearLimit, near);
      csr_write(RegJumpLimit, jump);
      csr_write(RegLowLimit, lo);
      csr_write(RegHighLimit, hi);
      settings_used++;
   endtask

   // drop valid, wait for every predicted word, then let the pipe settle
   // (a first word of a capture gives no result but may still be in flight)
   task automatic drain;
      req_if.valid <= 1'b0;
      while (filtered_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // first word alone with last, a two-word capture, a zero older sample
   task automatic test_fill_and_flush;
      send_word(24'h123456, 1'b1);
      send_word(24'h000001, 1'b0);
      send_word(24'h7FFFFF, 1'b1);
      // older sample zero: no filtering even far outside the window
      send_word(24'h000000, 1'b0);
      send_word(24'd3900000, 1'b0);
      send_word(24'd100, 1'b0);
      send_word(24'd3800000, 1'b1);
      captures_run += 3;
      drain();
   endtask

   // reset limits: spike repair, middle above high, both window sides
   task automatic test_despike_default;
      send_word(24'd3800000, 1'b0);
      send_word(24'd4500000, 1'b0);
      send_word(24'd3850000, 1'b0);
      send_word(24'd3000000, 1'b0);
      send_word(24'd4400000, 1'b0);
      send_word(24'd3900000, 1'b1);
      captures_run++;
      drain();
   endtask

   // wide-open repair with extreme bytes, saturation to both rails
   task automatic test_saturation_extremes;
      set_limits(24'hFFFFFF, 24'h000000, 24'h800000, 24'h7FFFFF);
      send_word(24'd8000000, 1'b0);
      send_word(24'd5, 1'b0);
      send_word(-24'sd8000000, 1'b0);
      send_word(24'd3, 1'b0);
      send_word(24'd8000000, 1'b0);
      send_word(24'h7FFFFF, 1'b0);
      send_word(24'h800000, 1'b0);
      send_word(24'hFFFFFF, 1'b0);
      send_word(24'hFF00FF, 1'b0);
      send_word(24'h000000, 1'b1);
      captures_run++;
      drain();
   endtask

   // one capture of random content, mostly a plausible signal
   task automatic run_capture(input int len, input bit noisy);
      sample_type  cur_s;
      int          cur, lo, hi;
      logic [23:0] raw;
      logic        last;
      lo = filter_cfg.low_limit;
      hi = filter_cfg.high_limit;
      cur = lo / 2 + hi / 2;
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         if (noisy) begin
            raw = 24'($urandom);
            if ($urandom_range(0, 15) == 0) last = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               5: cur = cur + ($urandom_range(0, 1) ? 1 : -1) *
                        (int'(filter_cfg.jump_limit) + int'($urandom_range(1, 300000)));
               6: cur = $urandom_range(0, 1) ? hi + int'($urandom_range(1, 500000))
                                             : lo - int'($urandom_range(1, 500000));
               7: cur = $urandom;
               8: case ($urandom_range(0, 2))
                     0: cur = int'(SampleMax);
                     1: cur = int'(SampleMin);
                     default: cur = 0;
                  endcase
               9: case ($urandom_range(0, 5))
                     0: cur = lo;
                     1: cur = hi;
                     2: cur = lo - 1;
                     3: cur = hi + 1;
                     4: cur = lo + 1;
                     default: cur = hi - 1;
                  endcase
               default: cur = cur + int'($urandom_range(0, 200000)) - 100000;
            endcase
            raw = cur[23:0];
         end
         // keep the walk inside the 24-bit range
         cur_s = raw;
         cur = cur_s;
         send_word(raw, last);
      end
      captures_run++;
   endtask

   // random captures under several limit settings, extremes included
   task automatic test_random_captures;
      int lo, hi, start;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_limits(NearLimitReset, JumpLimitReset, LowLimitReset, HighLimitReset);
            1: set_limits(24'hFFFFFF, 24'h000000, 24'h800000, 24'h7FFFFF);
            2: set_limits(24'h000000, 24'h000000, 24'h000000, 24'h000000);
            3: set_limits(24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000);
            default: begin
               lo = int'($urandom_range(0, 12000000)) - 6000000;
               hi = lo + int'($urandom_range(0, 2000000));
               set_limits(24'($urandom_range(0, 1000000)), 24'($urandom_range(0, 2000000)),
                          lo[23:0], hi[23:0]);
            end
         endcase
         start = words_sent;
         while (words_sent - start < PhaseWords) begin
            // stretches with and without gaps on each side
            sender_idle   = $urandom_range(0, 3) != 0;
            receiver_idle = $urandom_range(0, 3) != 0;
            run_capture($urandom_range(1, 24), $urandom_range(0, 9) == 0);
         end
         drain();
      end
   endtask

   // result side: random stall per word, every accepted word checked in order
   always @(posedge clock) begin : result_check
      word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            words_checked++;
            if (filtered_queue.size() == 0) begin
               $error("unexpected result word: sample %0d end_of_capture %0b",
                      rsp_if.sample, rsp_if.end_of_capture);
               fail_count++;
            end else begin
               want = filtered_queue.pop_front();
               if (rsp_if.sample !== want.sample) begin
                  $error("sample: expected %0d, actual %0d", want.sample, rsp_if.sample);
                  fail_count++;
               end
               if (rsp_if.end_of_capture !== want.end_of_capture) begin
                  $error("end_of_capture: expected %0b, actual %0b",
                         want.end_of_capture, rsp_if.end_of_capture);
                  fail_count++;
               end
            end
            rsp_wait = receiver_idle ? $urandom_range(0, 17) : 0;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      // every block input but rsp ready known from time zero; rsp ready low in reset
      reset            <= 1'b1;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      req_if.valid     <= 1'b0;
      req_if.byte_high <= 8'h00;
      req_if.byte_mid  <= 8'h00;
      req_if.byte_low  <= 8'h00;
      req_if.last      <= 1'b0;
      filter_cfg.near_limit = NearLimitReset;
      filter_cfg.jump_limit = JumpLimitReset;
      filter_cfg.low_limit  = LowLimitReset;
      filter_cfg.high_limit = HighLimitReset;
      held_older  = '0;
      held_middle = '0;
      held_count  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_flush();
      test_despike_default();
      test_saturation_extremes();
      test_random_captures();

      drain();
      $display("covered %0d sample words in %0d captures under %0d limit settings",
               words_sent, captures_run, settings_used);
      $display("checked %0d result words, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0 && filtered_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/adsf_pkg.sv
sv/adsf_if.sv
sv/adsf_csr.sv
sv/adsf_core.sv
sv/adsf_outq.sv
sv/adc_sample_despike_filter.sv
sv/adsf_checker.sv
test/tb_top.sv
